/* rtl/fbpa_pkg.sv */
// Shared types, field widths and codes of the fixed block page allocator.
package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 21;
    localparam int COUNT_W        = 7;
    localparam int FUNC_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_BLOCKS_DEF = 64;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPLIT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd16;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] block_address;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic              success;
        logic              page_full;
        logic              page_empty;
    } out_word_t;

    // Scan record that moves one cell along the chain each cycle.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] best_addr;
    } scan_rec_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic split;
        logic commit;
        logic is_alloc;
        logic is_free;
    } cell_ctl_t;

endpackage

/* rtl/fixed_block_page_allocator.sv */
// Top level of the fixed block page allocator: sequencer, registers and cell chain.
//
//  Channel  Signals                          Direction  Word
//  in       in_valid, in_stall, in_word      into block request (func, block_address)
//  out      out_valid, out_stall, out_word   out of     result and page flags
//  cfg      cfg_we, cfg_index, cfg_data      into block register write
//
// Allocate and free requests send a scan record down the chain of MAX_BLOCKS cells,
// one cell per cycle; no new request is accepted until the result has been emitted.
// Split and the unused request code skip the scan and go straight to the done state.
// Reset leaves no block free and none in use; the registers take their reset values.
// A result waits in the output register while out_stall is high; a later result waits
// in the sequencer until that register is taken.
module fixed_block_page_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fbpa_pkg::in_word_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fbpa_pkg::out_word_t            out_word,
    input  logic                           cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [ADDR_W-1:0]  want_reg;
    logic               start_reg;
    logic               start_next;
    logic               found_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [CNT_W-1:0]   free_cnt_reg;
    logic [CNT_W-1:0]   free_cnt_next;
    logic [CNT_W-1:0]   used_cnt_reg;
    logic [CNT_W-1:0]   used_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_word_t          out_word_reg;
    out_word_t          out_word_next;

    logic               accept;
    logic               emit;
    logic [CNT_W-1:0]   split_lim;
    cell_ctl_t          ctl;

    scan_rec_t          rec  [0:MAX_BLOCKS];
    logic [IDX_W-1:0]   idx  [0:MAX_BLOCKS];

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign emit     = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign split_lim = (CMP_W'(count_reg) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : CNT_W'(count_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        free_cnt_next  = free_cnt_reg;
        used_cnt_next  = used_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        ctl            = '0;
        ctl.is_alloc   = (func_reg == FUNC_ALLOC);
        ctl.is_free    = (func_reg == FUNC_FREE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_word.func == FUNC_ALLOC) || (in_word.func == FUNC_FREE))
                    begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rec[MAX_BLOCKS].active)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    out_word_next.alloc_address = '0;
                    out_word_next.success       = 1'b0;
                    case (func_reg)
                        FUNC_SPLIT:
                        begin
                            ctl.split             = 1'b1;
                            free_cnt_next         = split_lim;
                            used_cnt_next         = '0;
                            out_word_next.success = 1'b1;
                        end
                        FUNC_ALLOC:
                        begin
                            if (found_reg)
                            begin
                                ctl.commit                  = 1'b1;
                                free_cnt_next               = free_cnt_reg - 1'b1;
                                used_cnt_next               = used_cnt_reg + 1'b1;
                                out_word_next.alloc_address = res_addr_reg;
                                out_word_next.success       = 1'b1;
                            end
                        end
                        FUNC_FREE:
                        begin
                            // The matching cell has already released itself during the scan.
                            if (found_reg)
                            begin
                                free_cnt_next         = free_cnt_reg + 1'b1;
                                used_cnt_next         = used_cnt_reg - 1'b1;
                                out_word_next.success = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    out_word_next.page_full  = (free_cnt_next == '0);
                    out_word_next.page_empty = (used_cnt_next == '0);
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            free_cnt_reg  <= '0;
            used_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (accept)
        begin
            func_reg <= in_word.func;
            want_reg <= in_word.block_address;
        end
        if ((state_reg == ST_SCAN) && rec[MAX_BLOCKS].active)
        begin
            found_reg    <= rec[MAX_BLOCKS].found;
            res_addr_reg <= rec[MAX_BLOCKS].best_addr;
            res_idx_reg  <= idx[MAX_BLOCKS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Chain of block cells; the record enters at block 0 with the page base address.
    assign rec[0] = '{active: start_reg, found: 1'b0, addr: base_reg, best_addr: '0};
    assign idx[0] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        fbpa_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .commit_idx (res_idx_reg),
            .split_lim  (split_lim),
            .want       (want_reg),
            .block_size (size_reg),
            .rec_in     (rec[g]),
            .idx_in     (idx[g]),
            .rec_out    (rec[g+1]),
            .idx_out    (idx[g+1])
        );
    end

    // A scan record leaves the chain only while the sequencer waits for it.
    a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rec[MAX_BLOCKS].active |-> (state_reg == ST_SCAN))
        else $error("scan record left the chain outside the scan state");

    // Free and in-use blocks together never exceed the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+1)'(free_cnt_reg) + (CNT_W+1)'(used_cnt_reg)) <= (CNT_W+1)'(MAX_BLOCKS))
        else $error("block counts exceed the page size");

    // Only one scan is launched per request.
    a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |=> !start_reg)
        else $error("scan launched in consecutive cycles");

    // An allocate commit only follows a scan that found a free block.
    a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (found_reg && (free_cnt_reg != '0)))
        else $error("allocate commit without a free block");

endmodule

/* rtl/fbpa_cell.sv */
// One block cell: free and in-use bits plus one stage of the address scan.
module fbpa_cell #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fbpa_pkg::cell_ctl_t      ctl,
    input  logic [IDX_W-1:0]         commit_idx,
    input  logic [CNT_W-1:0]         split_lim,
    input  logic [fbpa_pkg::ADDR_W-1:0] want,
    input  logic [fbpa_pkg::SIZE_W-1:0] block_size,
    input  fbpa_pkg::scan_rec_t      rec_in,
    input  logic [IDX_W-1:0]         idx_in,
    output fbpa_pkg::scan_rec_t      rec_out,
    output logic [IDX_W-1:0]         idx_out
);
    import fbpa_pkg::*;

    logic            free_reg;
    logic            used_reg;
    logic            free_next;
    logic            used_next;
    scan_rec_t       rec_reg;
    scan_rec_t       rec_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic            take;
    logic            hit;

    // The incoming record carries this block's address; a free block with a
    // strictly lower address than the best so far wins, so ties keep the lower index.
    assign take = ctl.is_alloc && free_reg
                  && (!rec_in.found || (rec_in.addr < rec_in.best_addr));
    assign hit  = ctl.is_free && used_reg && !rec_in.found && (rec_in.addr == want);

    always_comb
    begin
        rec_next.active    = rec_in.active;
        rec_next.found     = rec_in.found || take || hit;
        rec_next.addr      = rec_in.addr + {{(ADDR_W-SIZE_W){1'b0}}, block_size};
        rec_next.best_addr = take ? rec_in.addr : rec_in.best_addr;
        idx_next           = take ? IDX_W'(CELL_IDX) : idx_in;
    end

    always_comb
    begin
        free_next = free_reg;
        used_next = used_reg;
        if (ctl.split)
        begin
            free_next = (CNT_W'(CELL_IDX) < split_lim);
            used_next = 1'b0;
        end
        else if (ctl.commit && (commit_idx == IDX_W'(CELL_IDX)))
        begin
            free_next = 1'b0;
            used_next = 1'b1;
        end
        else if (rec_in.active && hit)
        begin
            free_next = 1'b1;
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b0;
            used_reg <= 1'b0;
            rec_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            free_reg <= free_next;
            used_reg <= used_next;
            rec_reg  <= rec_next;
            idx_reg  <= idx_next;
        end
    end

    assign rec_out = rec_reg;
    assign idx_out = idx_reg;

endmodule

/* verif/tb_fixed_block_page_allocator.sv */
// Self-checking testbench for the fixed block page allocator.
`timescale 1ns / 1ps

module tb_fixed_block_page_allocator;
    import fbpa_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_MAX = 10;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    reg_val;
        in_word_t             req;
        logic                 typed;
        out_word_t            want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]    cfg_data = '0;

    // Shadow copy of the allocator state and registers.
    logic [NBLK-1:0]    free_blocks = '0;
    logic [NBLK-1:0]    used_blocks = '0;
    logic [ADDR_W-1:0]  page_base = '0;
    logic [SIZE_W-1:0]  blk_size = SIZE_RESET;
    logic [COUNT_W-1:0] blk_count = '0;

    out_word_t pending_results[$];
    row_t      plan[$];

    int errors = 0;
    int n_sent = 0;
    int n_grants = 0;
    int n_releases = 0;
    int n_splits = 0;
    int n_reg_writes = 0;
    int send_idle_pct = 32;
    int recv_stall_pct = 62;
    bit hold_go = 1'b0;
    int hold_left = 0;

    fixed_block_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [ADDR_W-1:0] block_addr(int i);
        logic [ADDR_W-1:0] idx;
        idx = i;
        return page_base + blk_size * idx;
    endfunction

    // Applies one request to the shadow state and returns the word it should produce.
    function automatic out_word_t allocator_step(in_word_t w);
        out_word_t         r;
        bit                found;
        int                best;
        int                n;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] best_a;
        r = '0;
        found = 1'b0;
        best = 0;
        best_a = '0;
        case (w.func)
            FUNC_SPLIT:
            begin
                n = (blk_count > NBLK) ? NBLK : blk_count;
                free_blocks = '0;
                used_blocks = '0;
                for (int i = 0; i < n; i++)
                    free_blocks[i] = 1'b1;
                r.success = 1'b1;
                n_splits++;
            end
            FUNC_ALLOC:
            begin
                for (int i = 0; i < NBLK; i++)
                begin
                    if (free_blocks[i])
                    begin
                        a = block_addr(i);
                        if (!found || a < best_a)
                        begin
                            found = 1'b1;
                            best = i;
                            best_a = a;
                        end
                    end
                end
                if (found)
                begin
                    free_blocks[best] = 1'b0;
                    used_blocks[best] = 1'b1;
                    r.alloc_address = best_a;
                    r.success = 1'b1;
                    n_grants++;
                end
            end
            FUNC_FREE:
            begin
                for (int i = 0; i < NBLK; i++)
                begin
                    if (!found && used_blocks[i] && block_addr(i) == w.block_address)
                    begin
                        found = 1'b1;
                        used_blocks[i] = 1'b0;
                        free_blocks[i] = 1'b1;
                    end
                end
                r.success = found;
                if (found)
                    n_releases++;
            end
            default:
            begin
            end
        endcase
        r.page_full = (free_blocks == '0);
        r.page_empty = (used_blocks == '0);
        return r;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_req(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a, bit typed,
                                    logic [ADDR_W-1:0] ea, logic ok, logic full,
                                    logic empty);
        row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.req.func = f;
        r.req.block_address = a;
        r.typed = typed;
        r.want.alloc_address = ea;
        r.want.success = ok;
        r.want.page_full = full;
        r.want.page_empty = empty;
        plan.insert(plan.size(), r);
    endfunction

    // Mostly well-formed traffic: frees usually name a block that is in use.
    function automatic in_word_t random_req(int alloc_pct);
        in_word_t w;
        int       r;
        int       k;
        w.block_address = $urandom();
        r = $urandom_range(99);
        if (r < 3)
            w.func = FUNC_SPLIT;
        else if (r < 6)
            w.func = FUNC_UNUSED;
        else if (r < 6 + alloc_pct)
            w.func = FUNC_ALLOC;
        else
        begin
            w.func = FUNC_FREE;
            r = $urandom_range(99);
            if (r < 75 && used_blocks != '0)
            begin
                k = $urandom_range(NBLK - 1);
                while (!used_blocks[k])
                    k = (k + 1) % NBLK;
                w.block_address = block_addr(k);
            end
            else if (r < 90)
                w.block_address = block_addr($urandom_range(NBLK - 1));
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_req(in_word_t w, bit typed, out_word_t want);
        out_word_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = allocator_step(w);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        n_sent++;
        if (n_sent == 350)
        begin
            send_idle_pct = 62;
            recv_stall_pct = 32;
        end
        else if (n_sent == 700)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_BASE:  page_base = val;
            CFG_SIZE:  blk_size = val[SIZE_W-1:0];
            CFG_COUNT: blk_count = val[COUNT_W-1:0];
            default:
            begin
            end
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                             logic [ADDR_W-1:0] count, int items, int alloc_pct,
                             int hold_at, int pause_at);
        in_word_t w;
        wait_drained();
        write_reg(CFG_BASE, base);
        write_reg(CFG_SIZE, size);
        write_reg(CFG_COUNT, count);
        w.func = FUNC_SPLIT;
        w.block_address = $urandom();
        send_req(w, 1'b0, '0);
        for (int k = 1; k < items; k++)
        begin
            if (k == hold_at)
                hold_go = 1'b1;
            if (k == pause_at)
                wait_drained();
            send_req(random_req(alloc_pct), 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected result word %h", out_word);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_word.alloc_address !== e.alloc_address
                    || out_word.success !== e.success
                    || out_word.page_full !== e.page_full
                    || out_word.page_empty !== e.page_empty)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                    begin
                        $display("ERROR: expected addr %h ok %b full %b empty %b",
                                 e.alloc_address, e.success, e.page_full, e.page_empty);
                        $display("       got      addr %h ok %b full %b empty %b",
                                 out_word.alloc_address, out_word.success,
                                 out_word.page_full, out_word.page_empty);
                    end
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        // Before any split nothing is free; a split with zero count frees nothing.
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1);
        add_req(FUNC_FREE, 32'h0, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1);
        add_req(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1);
        add_req(FUNC_SPLIT, 32'h0, 1'b1, 32'h0, 1'b1, 1'b1, 1'b1);
        add_cfg(CFG_BASE, 32'h0000_1000);
        add_cfg(CFG_COUNT, 32'd3);
        add_req(FUNC_SPLIT, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0000_1000, 1'b1, 1'b0, 1'b0);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0000_1010, 1'b1, 1'b0, 1'b0);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0000_1020, 1'b1, 1'b1, 1'b0);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0, 1'b0, 1'b1, 1'b0);
        add_req(FUNC_FREE, 32'h0000_1010, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'h0000_1010, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'h0000_1030, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'h0000_1010, 1'b1, 1'b1, 1'b0);
        // Count above the block limit, a stride of 0x100000, addresses that wrap.
        add_cfg(CFG_BASE, 32'hFFFF_FFF0);
        add_cfg(CFG_SIZE, 32'h0010_0000);
        add_cfg(CFG_COUNT, 32'd127);
        add_req(FUNC_SPLIT, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1);
        add_req(FUNC_ALLOC, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_ALLOC, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'hFFFF_FFF0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'h000F_FFF0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        // Zero stride: every block shares one address, so the lowest index wins.
        add_cfg(CFG_SIZE, 32'h0);
        add_cfg(CFG_BASE, 32'h0);
        add_req(FUNC_ALLOC, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_req(FUNC_UNUSED, 32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0);
        add_cfg(CFG_BASE, 32'hFFFF_FFC0);
        add_cfg(CFG_SIZE, 32'd1);
        add_cfg(CFG_COUNT, 32'd64);
        add_req(FUNC_SPLIT, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1);
        add_req(FUNC_ALLOC, 32'h0, 1'b1, 32'hFFFF_FFC0, 1'b1, 1'b0, 1'b0);
        add_req(FUNC_FREE, 32'hFFFF_FFC0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1);
        add_req(FUNC_FREE, 32'h5555_5555, 1'b1, 32'h0, 1'b0, 1'b0, 1'b1);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_req(plan[i].req, plan[i].typed, plan[i].want);
        end

        run_phase($urandom(), 32'd16, $urandom_range(8, 1), 170, 50, -1, -1);
        run_phase($urandom(), 32'd0, $urandom_range(64, 1), 170, 50, -1, -1);
        run_phase($urandom_range(32'hFFFF_FFFF, 32'hF000_0000),
                  $urandom_range(32'h0010_0000, 32'h0001_0000), 32'd64, 170, 70, -1, -1);
        run_phase($urandom(), $urandom_range(32'h0010_0000), 32'd127, 170, 65, -1, 60);
        run_phase($urandom(), $urandom_range(32'h0010_0000), $urandom_range(127),
                  170, 50, 30, -1);
        run_phase(32'h0, 32'd1, 32'd64, 170, 60, -1, -1);

        wait_drained();
        repeat (NBLK + 8) @(negedge clk);
        errors += pending_results.size();

        $display("Ran %0d requests over %0d register writes: %0d blocks handed out,",
                 n_sent, n_reg_writes, n_grants);
        $display("%0d blocks returned and %0d pages split.", n_releases, n_splits);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
